// File: rtl/core/rpc_pkg.sv
// shared types and constants for the rgba pixel combine alu
`default_nettype none

package rpc_pkg;

    localparam int unsigned ChW = 8;
    localparam int unsigned FactorW = 16;
    localparam int unsigned Lanes = 4;
    localparam int unsigned AlphaLane = 3;
    localparam logic [ChW-1:0] ChMax = 8'd255;

    typedef enum logic [2:0] {
        MODE_AVG      = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_SUB      = 3'd2,
        MODE_MODULATE = 3'd3,
        MODE_SCALE    = 3'd4,
        MODE_MERGE    = 3'd5
    } mode_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [ChW-1:0] mix;
        logic [ChW-1:0] sat_sum;
    } lane_res_t;

endpackage

`default_nettype wire

// File: rtl/core/rpc_lane.sv
// one channel lane: registered products, then mode select
`default_nettype none

module rpc_lane (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic [rpc_pkg::ChW-1:0]      a,
    input  wire logic [rpc_pkg::ChW-1:0]      b,
    input  wire logic [rpc_pkg::ChW-1:0]      weight,
    input  wire logic [rpc_pkg::FactorW-1:0]  factor,
    input  wire rpc_pkg::mode_t               mode_s1,
    output rpc_pkg::lane_res_t                res
);

    logic [rpc_pkg::ChW-1:0]                a_reg, a_next;
    logic [rpc_pkg::ChW-1:0]                b_reg, b_next;
    logic [2*rpc_pkg::ChW-1:0]              mod_reg, mod_next;
    logic [rpc_pkg::ChW-1:0]                scl_reg, scl_next;
    logic [2*rpc_pkg::ChW-1:0]              mrg_reg, mrg_next;
    logic [rpc_pkg::ChW+rpc_pkg::FactorW-1:0] scl_prod;
    logic [2*rpc_pkg::ChW-1:0]              wb_prod;
    logic [2*rpc_pkg::ChW-1:0]              wa_prod;
    logic [rpc_pkg::ChW-1:0]                inv_w;
    logic [rpc_pkg::ChW:0]                  sum;
    logic [2*rpc_pkg::ChW:0]                div_tmp;
    logic [rpc_pkg::ChW-1:0]                mrg_q;

    // stage 1: products
    always_comb
    begin
        inv_w    = rpc_pkg::ChMax - weight;
        scl_prod = {{rpc_pkg::FactorW{1'b0}}, a} * {{rpc_pkg::ChW{1'b0}}, factor};
        wb_prod  = {{rpc_pkg::ChW{1'b0}}, b} * {{rpc_pkg::ChW{1'b0}}, inv_w};
        wa_prod  = {{rpc_pkg::ChW{1'b0}}, a} * {{rpc_pkg::ChW{1'b0}}, weight};
        a_next   = a;
        b_next   = b;
        mod_next = {{rpc_pkg::ChW{1'b0}}, a} * {{rpc_pkg::ChW{1'b0}}, b};
        scl_next = scl_prod[2*rpc_pkg::ChW-1:rpc_pkg::ChW];
        // weights sum to 255, so this never overflows 16 bits
        mrg_next = wb_prod + wa_prod;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            mod_reg <= mod_next;
            scl_reg <= scl_next;
            mrg_reg <= mrg_next;
        end
    end

    // stage 2: finish and select
    always_comb
    begin
        sum     = {1'b0, a_reg} + {1'b0, b_reg};
        // x / 255 for x below 65535
        div_tmp = {1'b0, mrg_reg} + (2*rpc_pkg::ChW+1)'(1)
                  + {{(rpc_pkg::ChW+1){1'b0}}, mrg_reg[2*rpc_pkg::ChW-1:rpc_pkg::ChW]};
        mrg_q   = div_tmp[2*rpc_pkg::ChW-1:rpc_pkg::ChW];
        res.sat_sum = sum[rpc_pkg::ChW] ? rpc_pkg::ChMax : sum[rpc_pkg::ChW-1:0];
        unique case (mode_s1)
            rpc_pkg::MODE_AVG:      res.mix = sum[rpc_pkg::ChW:1];
            rpc_pkg::MODE_ADD:      res.mix = res.sat_sum;
            rpc_pkg::MODE_SUB:      res.mix = (a_reg > b_reg) ? (a_reg - b_reg)
                                                              : '0;
            rpc_pkg::MODE_MODULATE: res.mix = mod_reg[2*rpc_pkg::ChW-1:rpc_pkg::ChW];
            rpc_pkg::MODE_SCALE:    res.mix = scl_reg;
            rpc_pkg::MODE_MERGE:    res.mix = mrg_q;
            default:                res.mix = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rgba_pixel_combine_alu.sv
// top level: four channel lanes, alpha merge and output register
`default_nettype none

// Combines two RGBA8 pixels into one per word: average, saturating add,
// clamped subtract, modulate, Q8.8 scale of the first pixel (low 8 bits
// kept) or source-over merge weighted by the first alpha. Four identical
// lanes handle red, green, blue and alpha side by side; the merge stage
// swaps in the saturated alpha sum for merge mode. Each word passes the
// product register, then the output register, and one word is taken every
// cycle while the output side keeps taking results. Mode codes 6 and 7
// give an all-zero pixel.

module rgba_pixel_combine_alu (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   mode,
    input  wire logic [7:0]   first_red,
    input  wire logic [7:0]   first_green,
    input  wire logic [7:0]   first_blue,
    input  wire logic [7:0]   first_alpha,
    input  wire logic [7:0]   second_red,
    input  wire logic [7:0]   second_green,
    input  wire logic [7:0]   second_blue,
    input  wire logic [7:0]   second_alpha,
    input  wire logic [15:0]  scale_factor,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic [7:0]        out_alpha
);

    logic                       v1_reg, v1_next;
    logic                       v2_reg, v2_next;
    logic                       adv1, adv2;
    rpc_pkg::mode_t             mode_reg, mode_next;
    logic [rpc_pkg::ChW-1:0]    a_ch [rpc_pkg::Lanes];
    logic [rpc_pkg::ChW-1:0]    b_ch [rpc_pkg::Lanes];
    rpc_pkg::lane_res_t         lane_res [rpc_pkg::Lanes];
    logic [rpc_pkg::ChW-1:0]    pix_reg [rpc_pkg::Lanes];
    logic [rpc_pkg::ChW-1:0]    pix_next [rpc_pkg::Lanes];

    assign a_ch[0] = first_red;
    assign a_ch[1] = first_green;
    assign a_ch[2] = first_blue;
    assign a_ch[3] = first_alpha;
    assign b_ch[0] = second_red;
    assign b_ch[1] = second_green;
    assign b_ch[2] = second_blue;
    assign b_ch[3] = second_alpha;

    always_comb
    begin
        adv2      = !v2_reg || out_ready;
        adv1      = !v1_reg || adv2;
        v1_next   = adv1 ? in_valid : v1_reg;
        v2_next   = adv2 ? v1_reg : v2_reg;
        mode_next = rpc_pkg::mode_t'(mode);
    end

    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            mode_reg <= mode_next;
        end
    end

    for (genvar i = 0; i < rpc_pkg::Lanes; i++)
    begin : g_lane
        rpc_lane u_lane (
            .clk     (clk),
            .load    (adv1),
            .a       (a_ch[i]),
            .b       (b_ch[i]),
            .weight  (first_alpha),
            .factor  (scale_factor),
            .mode_s1 (mode_reg),
            .res     (lane_res[i])
        );
    end

    // merge stage: alpha takes the saturated sum in merge mode
    always_comb
    begin
        for (int i = 0; i < rpc_pkg::Lanes; i++)
        begin
            pix_next[i] = lane_res[i].mix;
        end
        if (mode_reg == rpc_pkg::MODE_MERGE)
        begin
            pix_next[rpc_pkg::AlphaLane] = lane_res[rpc_pkg::AlphaLane].sat_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            for (int i = 0; i < rpc_pkg::Lanes; i++)
            begin
                pix_reg[i] <= pix_next[i];
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_red   = pix_reg[0];
    assign out_green = pix_reg[1];
    assign out_blue  = pix_reg[2];
    assign out_alpha = pix_reg[3];

`ifndef SYNTHESIS
    // only a full, stalled pipeline may refuse a word
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && !out_ready))
        else $error("in_ready low without a full stalled pipeline");

    // a word in stage 1 is never dropped while the output stalls
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv2) |=> v1_reg)
        else $error("stage 1 word lost under stall");

    // a result leaves only when taken
    a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(v2_reg) |-> $past(out_ready))
        else $error("result dropped without out_ready");

    // every word accepted at the input reaches stage 1
    a_fill_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted word missing from stage 1");
`endif

endmodule

`default_nettype wire

// File: test/tb_rgba_pixel_combine_alu.sv
// testbench for rgba_pixel_combine_alu: random handshake traffic checked against a blend predictor
module tb_rgba_pixel_combine_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 5;
    localparam int TIMEOUT_NS = 1_000_000;
    localparam int RANDOM_WORDS = 1050;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 400;
    localparam int REPORT_LIMIT = 10;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef logic [3:0][7:0] rgba_t;

    typedef struct packed {
        logic [2:0]  mode;
        rgba_t       first;
        rgba_t       second;
        logic [15:0] factor;
        logic        drain;
    } pix_word_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [7:0]  first_red = '0;
    logic [7:0]  first_green = '0;
    logic [7:0]  first_blue = '0;
    logic [7:0]  first_alpha = '0;
    logic [7:0]  second_red = '0;
    logic [7:0]  second_green = '0;
    logic [7:0]  second_blue = '0;
    logic [7:0]  second_alpha = '0;
    logic [15:0] scale_factor = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;

    pix_word_t pending_words[$];
    rgba_t     pixels_due[$];
    pix_word_t cur_word;
    int        words_sent = 0;
    int        results_seen = 0;
    int        total_words = 0;
    int        errors = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    string     lane_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    rgba_pixel_combine_alu u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .first_alpha  (first_alpha),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .second_alpha (second_alpha),
        .scale_factor (scale_factor),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [7:0] mix_lane(logic [2:0] m, logic [7:0] a, logic [7:0] b,
                                            logic [15:0] factor, logic [7:0] weight);
        logic [8:0]  sum;
        logic [15:0] prod;
        logic [23:0] scaled;
        logic [16:0] blend;
        sum = a + b;
        prod = a * b;
        scaled = a * factor;
        // weights sum to 255, so the weighted sum tops out at 255*255
        blend = (b * (rpc_pkg::ChMax - weight) + a * weight) / rpc_pkg::ChMax;
        case (m)
            rpc_pkg::MODE_AVG:      return sum[8:1];
            rpc_pkg::MODE_ADD:      return (sum > rpc_pkg::ChMax) ? rpc_pkg::ChMax : sum[7:0];
            rpc_pkg::MODE_SUB:      return (a > b) ? a - b : 8'd0;
            rpc_pkg::MODE_MODULATE: return prod[15:8];
            rpc_pkg::MODE_SCALE:    return scaled[15:8];
            rpc_pkg::MODE_MERGE:    return (blend > rpc_pkg::ChMax) ? rpc_pkg::ChMax
                                                                    : blend[7:0];
            default:                return 8'd0;
        endcase
    endfunction

    function automatic rgba_t blend_pixel(pix_word_t w);
        rgba_t      px;
        logic [8:0] alpha_sum;
        for (int k = 0; k < rpc_pkg::Lanes; k++)
            px[k] = mix_lane(w.mode, w.first[k], w.second[k], w.factor,
                             w.first[rpc_pkg::AlphaLane]);
        if (w.mode == rpc_pkg::MODE_MERGE)
        begin
            alpha_sum = w.first[rpc_pkg::AlphaLane] + w.second[rpc_pkg::AlphaLane];
            px[rpc_pkg::AlphaLane] = (alpha_sum > rpc_pkg::ChMax) ? rpc_pkg::ChMax
                                                                  : alpha_sum[7:0];
        end
        return px;
    endfunction

    function automatic rgba_t pack_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 16'h01FF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_word(logic [2:0] m, rgba_t a, rgba_t b, logic [15:0] factor,
                            logic drain);
        pix_word_t w;
        w.mode = m;
        w.first = a;
        w.second = b;
        w.factor = factor;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    // sender: bursts of random length with random gaps, optional drain before a word
    always @(posedge clk)
    begin
        logic      fire;
        pix_word_t nxt;
        fire = in_valid && in_ready;
        if (rst_n)
        begin
            if (fire)
            begin
                pixels_due.push_back(blend_pixel(cur_word));
                words_sent <= words_sent + 1;
            end
            if (!in_valid || fire)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain &&
                           (fire || words_sent != results_seen)))
                begin
                    nxt = pending_words.pop_front();
                    cur_word = nxt;
                    mode <= nxt.mode;
                    first_red <= nxt.first[0];
                    first_green <= nxt.first[1];
                    first_blue <= nxt.first[2];
                    first_alpha <= nxt.first[3];
                    second_red <= nxt.second[0];
                    second_green <= nxt.second[1];
                    second_blue <= nxt.second[2];
                    second_alpha <= nxt.second[3];
                    scale_factor <= nxt.factor;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall style changes per phase, plus one long hold-off
    always @(posedge clk)
    begin
        stall_style_t style;
        int           phase_left;
        int           hold_left;
        bit           hold_done;
        logic [7:0]   pattern;
        bit [2:0]     pat_idx;
        if (rst_n)
        begin
            if (phase_left == 0)
            begin
                style = stall_style_t'($urandom_range(STALL_NONE, STALL_PATTERN));
                phase_left = $urandom_range(32, 256);
                pattern = 8'($urandom) | 8'h01;
            end
            else
            begin
                phase_left = phase_left - 1;
            end
            pat_idx = pat_idx + 3'd1;
            if (!hold_done && words_sent >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    STALL_NONE:  out_ready <= 1'b1;
                    STALL_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ready <= pattern[pat_idx];
                endcase
            end
        end
    end

    // check each result word against the oldest predicted pixel
    always @(posedge clk)
    begin
        rgba_t seen;
        rgba_t want;
        logic  bad;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {out_alpha, out_blue, out_green, out_red};
            results_seen <= results_seen + 1;
            if (pixels_due.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected word: %0d %0d %0d %0d", out_red, out_green,
                             out_blue, out_alpha);
            end
            else
            begin
                want = pixels_due.pop_front();
                bad = 1'b0;
                for (int k = 0; k < rpc_pkg::Lanes; k++)
                    if (seen[k] !== want[k])
                        bad = 1'b1;
                if (bad)
                begin
                    errors = errors + 1;
                    if (errors <= REPORT_LIMIT)
                        for (int k = 0; k < rpc_pkg::Lanes; k++)
                            if (seen[k] !== want[k])
                                $display("mismatch on word %0d: %s expected %0d got %0d",
                                         results_seen, lane_name[k], want[k], seen[k]);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[rgba_pixel_combine_alu] ERROR");
        $finish;
    end

    initial
    begin
        logic [2:0] m;
        // extremes of every mode
        add_word(rpc_pkg::MODE_AVG, pack_px(255, 255, 255, 255),
                 pack_px(255, 255, 255, 255), 0, 0);
        add_word(rpc_pkg::MODE_AVG, pack_px(0, 0, 0, 0), pack_px(0, 0, 0, 0), 16'hFFFF, 0);
        add_word(rpc_pkg::MODE_AVG, pack_px(1, 2, 3, 254), pack_px(0, 255, 128, 1), 0, 0);
        add_word(rpc_pkg::MODE_ADD, pack_px(255, 255, 255, 255),
                 pack_px(255, 255, 255, 255), 0, 0);
        add_word(rpc_pkg::MODE_ADD, pack_px(100, 0, 127, 128),
                 pack_px(100, 255, 128, 127), 0, 0);
        add_word(rpc_pkg::MODE_SUB, pack_px(0, 0, 0, 0), pack_px(255, 255, 255, 255), 0, 0);
        add_word(rpc_pkg::MODE_SUB, pack_px(255, 128, 7, 200), pack_px(0, 127, 8, 200), 0, 0);
        add_word(rpc_pkg::MODE_MODULATE, pack_px(255, 255, 255, 255),
                 pack_px(255, 255, 255, 255), 0, 0);
        add_word(rpc_pkg::MODE_MODULATE, pack_px(128, 1, 255, 16),
                 pack_px(2, 255, 0, 16), 0, 0);
        // zero factor clears every channel
        add_word(rpc_pkg::MODE_SCALE, pack_px(255, 255, 255, 255), pack_px(9, 9, 9, 9),
                 16'h0000, 0);
        add_word(rpc_pkg::MODE_SCALE, pack_px(255, 1, 128, 0), pack_px(0, 0, 0, 0),
                 16'hFFFF, 0);
        add_word(rpc_pkg::MODE_SCALE, pack_px(12, 34, 56, 78), pack_px(255, 255, 255, 255),
                 16'h0100, 0);
        // products of 256 and above wrap
        add_word(rpc_pkg::MODE_SCALE, pack_px(200, 100, 171, 255), pack_px(0, 0, 0, 0),
                 16'h0180, 0);
        add_word(rpc_pkg::MODE_MERGE, pack_px(10, 20, 30, 0),
                 pack_px(200, 210, 220, 100), 0, 0);
        add_word(rpc_pkg::MODE_MERGE, pack_px(255, 0, 90, 255), pack_px(0, 255, 1, 255), 0, 0);
        add_word(rpc_pkg::MODE_MERGE, pack_px(255, 255, 0, 128),
                 pack_px(0, 255, 255, 127), 0, 0);
        add_word(rpc_pkg::MODE_MERGE, pack_px(0, 0, 0, 0), pack_px(0, 0, 0, 0), 0, 0);
        // unused mode codes give an all-zero pixel
        add_word(MODE_UNUSED_LO, pack_px(255, 255, 255, 255), pack_px(255, 255, 255, 255),
                 16'hFFFF, 0);
        add_word(MODE_UNUSED_HI, pack_px(17, 200, 3, 99), pack_px(255, 0, 44, 1), 16'h1234, 0);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else
                m = 3'($urandom_range(rpc_pkg::MODE_AVG, rpc_pkg::MODE_MERGE));
            // sender waits for an empty pipe before random words 0 and 600
            add_word(m, pack_px(pick_channel(), pick_channel(), pick_channel(), pick_channel()),
                     pack_px(pick_channel(), pick_channel(), pick_channel(), pick_channel()),
                     pick_factor(), (i == 0 || i == 600));
        end
        total_words = pending_words.size();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (results_seen != total_words)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pixels_due.size() == 0)
        begin
            $display("[rgba_pixel_combine_alu] OK");
        end
        else
        begin
            $display("[rgba_pixel_combine_alu] ERROR");
        end
        $finish;
    end

endmodule
